// ----- design/v110ad_pkg.sv -----
// ----------------------------------------------------------------------------
// v110ad_pkg
// Shared types, constants and the per-line decode step of the V.110
// asynchronous receive deframer.
// ----------------------------------------------------------------------------
package v110ad_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_RATE_MODE   = 1'b0;
    localparam logic REG_SYNC_FRAMES = 1'b1;

    localparam logic [1:0] RATE_X1 = 2'd0;
    localparam logic [1:0] RATE_X2 = 2'd1;
    localparam logic [1:0] RATE_X4 = 2'd2;

    localparam logic [2:0] SYNC_RESET = 3'd5;

    localparam logic [5:0] HDR_X1   = 6'd1;
    localparam logic [5:0] HDR_X2   = 6'd2;
    localparam logic [5:0] HDR_X4   = 6'd4;
    localparam logic [5:0] FRAME_X1 = 6'd10;
    localparam logic [5:0] FRAME_X2 = 6'd20;
    localparam logic [5:0] FRAME_X4 = 6'd40;

    localparam logic [3:0] EBIT_PATTERN = 4'hd;
    localparam logic [6:0] DATA_MASK    = 7'h7e;
    localparam logic [6:0] ALL_STOP     = 7'h7e;
    localparam logic [6:0] LAST_START   = 7'h3e;

    localparam int         NUM_LINES   = 8;
    localparam logic [2:0] LAST_LINE   = 3'd7;
    localparam int         CTS_LINE    = 5;
    localparam logic [2:0] MAX_RESULTS = 3'd5;

    typedef struct packed {
        logic [NUM_LINES-1:0][7:0] lines;
    } t_frame;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       char_valid;
        logic       stop_error;
        logic       remote_cts;
        logic       synced;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [3:0] bp;
        logic [7:0] pc;
        logic       emit;
        logic       stop;
    } t_step;

    function automatic t_step line_step(input logic [3:0] bp, input logic [7:0] pc,
                                        input logic [7:0] oct);
        logic [6:0]  t;
        logic [5:0]  u;
        logic [15:0] wide;
        logic [3:0]  b;
        logic [7:0]  p;
        logic [2:0]  first;
        logic        done;
        t_step       r;
        r     = '0;
        t     = oct[6:0] & DATA_MASK;
        u     = t[6:1];
        b     = bp;
        p     = pc;
        first = 3'd6;
        done  = 1'b0;
        wide  = '0;
        if (bp == 4'd0) begin
            if (t == LAST_START) begin
                b = 4'd1;
                p = 8'd0;
            end else if (t != ALL_STOP) begin
                // hunt the start bit: first zero among the data bits
                for (int i = 1; i <= 6; i++) begin
                    if (!done && !t[i]) begin
                        first = 3'(i);
                        done  = 1'b1;
                    end
                end
                b = 4'd7 - {1'b0, first};
                p = 8'({1'b0, t} >> (4'({1'b0, first}) + 4'd1));
            end
        end else begin
            if (bp < 4'd9) begin
                wide = {10'd0, u} << (bp - 4'd1);
                p    = pc | wide[7:0];
                if (bp <= 4'd3) begin
                    b = bp + 4'd6;
                end else begin
                    u = u >> (4'd9 - bp);
                end
            end
            if (bp > 4'd3) begin
                r.emit = 1'b1;
                r.stop = u[0];
                r.pc   = p;
                u      = u >> 1;
                b      = bp - 4'd4;
                done   = 1'b0;
                // skip stop bits up to the next start bit
                for (int i = 0; i < 6; i++) begin
                    if (!done && b != 4'd0 && u[0]) begin
                        u = u >> 1;
                        b = b - 4'd1;
                    end else begin
                        done = 1'b1;
                    end
                end
                if (b > 4'd1) begin
                    p = 8'(u >> 1);
                end else if (b == 4'd1) begin
                    p = 8'd0;
                end
            end
        end
        // the emitted character is taken before the hunt overwrites it
        if (r.emit) begin
            r.stop = r.stop;
        end
        r.bp = b;
        if (r.emit) begin
            r.pc = (bp < 4'd9) ? (pc | wide[7:0]) : pc;
        end
        return r;
    endfunction

    function automatic logic [7:0] next_pc(input logic [3:0] bp, input logic [7:0] pc,
                                           input logic [7:0] oct);
        logic [6:0]  t;
        logic [5:0]  u;
        logic [15:0] wide;
        logic [3:0]  b;
        logic [7:0]  p;
        logic [2:0]  first;
        logic        done;
        t     = oct[6:0] & DATA_MASK;
        u     = t[6:1];
        b     = bp;
        p     = pc;
        first = 3'd6;
        done  = 1'b0;
        wide  = '0;
        if (bp == 4'd0) begin
            if (t == LAST_START) begin
                p = 8'd0;
            end else if (t != ALL_STOP) begin
                for (int i = 1; i <= 6; i++) begin
                    if (!done && !t[i]) begin
                        first = 3'(i);
                        done  = 1'b1;
                    end
                end
                p = 8'({1'b0, t} >> (4'({1'b0, first}) + 4'd1));
            end
        end else begin
            if (bp < 4'd9) begin
                wide = {10'd0, u} << (bp - 4'd1);
                p    = pc | wide[7:0];
                if (bp > 4'd3) begin
                    u = u >> (4'd9 - bp);
                end
            end
            if (bp > 4'd3) begin
                u    = u >> 1;
                b    = bp - 4'd4;
                done = 1'b0;
                for (int i = 0; i < 6; i++) begin
                    if (!done && b != 4'd0 && u[0]) begin
                        u = u >> 1;
                        b = b - 4'd1;
                    end else begin
                        done = 1'b1;
                    end
                end
                if (b > 4'd1) begin
                    p = 8'(u >> 1);
                end else if (b == 4'd1) begin
                    p = 8'd0;
                end
            end
        end
        return p;
    endfunction

endpackage

// ----- design/v110ad_front.sv -----
// ----------------------------------------------------------------------------
// v110ad_front
// Hunts the frame header, packs samples into lines 1..9 and forwards
// frames whose E-bits and alignment bits check out.
// ----------------------------------------------------------------------------
module v110ad_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_rate_mode,
    input  logic                 i_rate_wr,
    input  logic                 i_accept,
    input  logic [7:0]           i_sample,
    output logic                 o_fr_push,
    output v110ad_pkg::t_frame   o_frame
);

    logic [5:0] r_fill;
    logic [5:0] n_fill;
    logic [7:0] r_oct [0:8];
    logic [7:0] n_oct [0:8];

    logic [5:0] hdr_len;
    logic [5:0] frame_len;
    logic       hdr_bad;
    logic [3:0] idx;
    logic [7:0] data;
    logic [5:0] fill_plus;
    logic       ones;
    logic       w_fr_end;

    always_comb begin
        case (i_rate_mode)
            v110ad_pkg::RATE_X1: begin
                hdr_len   = v110ad_pkg::HDR_X1;
                frame_len = v110ad_pkg::FRAME_X1;
                hdr_bad   = (i_sample != 8'd0);
                idx       = r_fill[3:0];
                data      = i_sample;
            end
            v110ad_pkg::RATE_X2: begin
                hdr_len   = v110ad_pkg::HDR_X2;
                frame_len = v110ad_pkg::FRAME_X2;
                hdr_bad   = |i_sample[2:0];
                idx       = r_fill[4:1];
                data      = {4'd0, i_sample[3:0]} << {r_fill[0], 2'b00};
            end
            default: begin
                hdr_len   = v110ad_pkg::HDR_X4;
                frame_len = v110ad_pkg::FRAME_X4;
                hdr_bad   = |i_sample[1:0];
                idx       = r_fill[5:2];
                data      = {6'd0, i_sample[1:0]} << {r_fill[1:0], 1'b0};
            end
        endcase
    end

    always_comb begin
        fill_plus = r_fill + 6'd1;
        n_fill    = r_fill;
        n_oct     = r_oct;
        w_fr_end  = 1'b0;
        if (i_accept) begin
            if (r_fill < hdr_len) begin
                if (hdr_bad) begin
                    n_fill = 6'd0;
                end else begin
                    n_fill = fill_plus;
                    if (fill_plus == hdr_len) begin
                        for (int j = 0; j < 9; j++) begin
                            n_oct[j] = 8'd0;
                        end
                    end
                end
            end else begin
                for (int j = 0; j < 9; j++) begin
                    if (idx == 4'(j + 1)) begin
                        n_oct[j] = r_oct[j] | data;
                    end
                end
                n_fill = fill_plus;
                if (fill_plus == frame_len) begin
                    n_fill   = 6'd0;
                    w_fr_end = 1'b1;
                end
            end
        end
        if (i_rate_wr) begin
            n_fill = 6'd0;
        end
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            o_frame.lines[j]     = n_oct[j];
            o_frame.lines[j + 4] = n_oct[j + 5];
        end
        ones = 1'b1;
        for (int j = 0; j < v110ad_pkg::NUM_LINES; j++) begin
            ones = ones & o_frame.lines[j][0];
        end
    end

    logic w_frame_ok;
    assign w_frame_ok = ones && (n_oct[4][3:0] == v110ad_pkg::EBIT_PATTERN);

    // rejected frames are dropped here
    assign o_fr_push = w_fr_end && w_frame_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 6'd0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oct <= n_oct;
    end

endmodule

// ----- design/v110ad_frame_q.sv -----
// ----------------------------------------------------------------------------
// v110ad_frame_q
// Two-entry queue of checked frames between the front and the back.
// ----------------------------------------------------------------------------
module v110ad_frame_q (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  v110ad_pkg::t_frame   i_data,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output v110ad_pkg::t_frame   o_head
);

    v110ad_pkg::t_frame r_mem [0:1];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- design/v110ad_res_q.sv -----
// ----------------------------------------------------------------------------
// v110ad_res_q
// Two-entry output queue of decoded character words.
// ----------------------------------------------------------------------------
module v110ad_res_q (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  v110ad_pkg::t_result  i_data,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output v110ad_pkg::t_result  o_head
);

    v110ad_pkg::t_result r_mem [0:1];
    logic                r_wp;
    logic                r_rp;
    logic [1:0]          r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- design/v110ad_back.sv -----
// ----------------------------------------------------------------------------
// v110ad_back
// Takes one checked frame at a time, updates sync and cts; while the result
// queue has room it walks eight data lines one per cycle for start/stop chars.
// ----------------------------------------------------------------------------
module v110ad_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [2:0]           i_sync_frames,
    input  logic                 i_sync_wr,
    input  logic                 i_fq_empty,
    input  v110ad_pkg::t_frame   i_fq_head,
    output logic                 o_fq_pop,
    input  logic                 i_rq_full,
    output logic                 o_rq_push,
    output v110ad_pkg::t_result  o_rq_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]          r_state,  n_state;
    v110ad_pkg::t_frame  r_frame,  n_frame;
    logic [2:0]          r_line,   n_line;
    logic [2:0]          r_nres,   n_nres;
    logic                r_pend_v, n_pend_v;
    v110ad_pkg::t_result r_pend,   n_pend;
    logic [3:0]          r_bp,     n_bp;
    logic [7:0]          r_pc,     n_pc;
    logic [2:0]          r_cnt,    n_cnt;
    logic                r_cts,    n_cts;

    v110ad_pkg::t_step   w_step;
    logic [7:0]          w_pc_next;
    logic [7:0]          w_oct;

    assign w_oct     = r_frame.lines[r_line];
    assign w_step    = v110ad_pkg::line_step(r_bp, r_pc, w_oct);
    assign w_pc_next = v110ad_pkg::next_pc(r_bp, r_pc, w_oct);

    always_comb begin
        n_state   = r_state;
        n_frame   = r_frame;
        n_line    = r_line;
        n_nres    = r_nres;
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        n_bp      = r_bp;
        n_pc      = r_pc;
        n_cnt     = r_cnt;
        n_cts     = r_cts;
        o_fq_pop  = 1'b0;
        o_rq_push = 1'b0;
        o_rq_data = r_pend;
        o_rq_data.last = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_fq_empty) begin
                    o_fq_pop = 1'b1;
                    n_frame  = i_fq_head;
                    n_line   = 3'd0;
                    n_nres   = 3'd0;
                    n_pend_v = 1'b0;
                    n_state  = ST_RUN;
                    if (r_cnt != 3'd0) begin
                        n_cnt = r_cnt - 3'd1;
                    end else begin
                        n_cts = i_fq_head.lines[v110ad_pkg::CTS_LINE][7];
                    end
                end
            end
            ST_RUN: begin
                if (!i_rq_full) begin
                    n_bp = w_step.bp;
                    n_pc = w_pc_next;
                    if (w_step.emit && r_nres < v110ad_pkg::MAX_RESULTS) begin
                        n_nres            = r_nres + 3'd1;
                        n_pend_v          = 1'b1;
                        n_pend.char_byte  = w_step.pc;
                        n_pend.char_valid = w_step.stop;
                        n_pend.stop_error = ~w_step.stop;
                        n_pend.remote_cts = r_cts;
                        n_pend.synced     = (r_cnt == 3'd0);
                        n_pend.last       = 1'b0;
                        o_rq_push         = r_pend_v;
                    end
                    if (r_line == v110ad_pkg::LAST_LINE) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_line = r_line + 3'd1;
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_rq_full) begin
                    // the held character closes the frame
                    o_rq_push      = r_pend_v;
                    o_rq_data.last = 1'b1;
                    n_pend_v       = 1'b0;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (i_sync_wr) begin
            n_cnt = i_sync_frames;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_line   <= 3'd0;
            r_nres   <= 3'd0;
            r_pend_v <= 1'b0;
            r_bp     <= 4'd0;
            r_pc     <= 8'd0;
            r_cnt    <= v110ad_pkg::SYNC_RESET;
            r_cts    <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_line   <= n_line;
            r_nres   <= n_nres;
            r_pend_v <= n_pend_v;
            r_bp     <= n_bp;
            r_pc     <= n_pc;
            r_cnt    <= n_cnt;
            r_cts    <= n_cts;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
        r_pend  <= n_pend;
    end

endmodule

// ----- design/v110_async_deframer_core.sv -----
// ----------------------------------------------------------------------------
// v110_async_deframer_core
// V.110 asynchronous receive deframer: samples in, start/stop characters out.
// ----------------------------------------------------------------------------
// Input channel: one B-channel sample word per push while full is low.
// Output channel: one character word per pop while empty is low; each word
// carries the character, its stop-bit status, remote cts, sync status and a
// last flag on the final word of a frame.
// The front takes one sample every cycle while full is low and hunts/assembles
// frames; checked frames enter a two-entry frame queue. The back decodes one
// data line per cycle while the output queue has room; per frame it first
// loads the frame and updates sync, then walks the eight lines, then closes.
// Samples are taken every cycle that full is low; full rises only while two
// decoded-pending frames sit in the queue, which needs frames shorter than
// the back's time. When the receiver stops popping, the two-entry output queue
// fills, the back holds, the frame queue fills and full goes high; nothing is
// dropped by that, though the back keeps at most five characters per frame.
// Reset clears the queues, header hunting, the character hunter and sets
// rate_mode to two bits per sample, sync_frames and its countdown to 5 and
// cts to not ready. Registers at byte 0 (rate_mode) and byte 4 (sync_frames).
// ----------------------------------------------------------------------------
module v110_async_deframer_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [v110ad_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [v110ad_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [v110ad_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                 pready,
    input  logic                                 push,
    output logic                                 full,
    input  logic [7:0]                           i_sample_byte,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [7:0]                           o_char_byte,
    output logic                                 o_char_valid,
    output logic                                 o_stop_error,
    output logic                                 o_remote_cts,
    output logic                                 o_synced,
    output logic                                 o_last
);

    logic [1:0] r_rate_mode;
    logic [2:0] r_sync_frames;

    logic w_cfg_wr;
    logic w_rate_wr;
    logic w_sync_wr;
    logic w_in_acc;

    logic                w_fq_push;
    logic                w_fq_pop;
    logic                w_fq_full;
    logic                w_fq_empty;
    v110ad_pkg::t_frame  w_frame;
    v110ad_pkg::t_frame  w_fq_head;

    logic                w_rq_push;
    logic                w_rq_full;
    v110ad_pkg::t_result w_rq_data;
    v110ad_pkg::t_result w_rq_head;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_rate_wr = w_cfg_wr && (paddr[2] == v110ad_pkg::REG_RATE_MODE);
    assign w_sync_wr = w_cfg_wr && (paddr[2] == v110ad_pkg::REG_SYNC_FRAMES);
    assign w_in_acc  = push & ~w_fq_full;
    assign full      = w_fq_full;

    always_comb begin
        case (paddr[2])
            v110ad_pkg::REG_RATE_MODE:   prdata = {30'd0, r_rate_mode};
            v110ad_pkg::REG_SYNC_FRAMES: prdata = {29'd0, r_sync_frames};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_mode   <= v110ad_pkg::RATE_X4;
            r_sync_frames <= v110ad_pkg::SYNC_RESET;
        end else begin
            if (w_rate_wr) begin
                r_rate_mode <= pwdata[1:0];
            end
            if (w_sync_wr) begin
                r_sync_frames <= pwdata[2:0];
            end
        end
    end

    v110ad_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rate_mode (r_rate_mode),
        .i_rate_wr   (w_rate_wr),
        .i_accept    (w_in_acc),
        .i_sample    (i_sample_byte),
        .o_fr_push   (w_fq_push),
        .o_frame     (w_frame)
    );

    v110ad_frame_q u_frame_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fq_push),
        .i_data  (w_frame),
        .i_pop   (w_fq_pop),
        .o_full  (w_fq_full),
        .o_empty (w_fq_empty),
        .o_head  (w_fq_head)
    );

    v110ad_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sync_frames (pwdata[2:0]),
        .i_sync_wr     (w_sync_wr),
        .i_fq_empty    (w_fq_empty),
        .i_fq_head     (w_fq_head),
        .o_fq_pop      (w_fq_pop),
        .i_rq_full     (w_rq_full),
        .o_rq_push     (w_rq_push),
        .o_rq_data     (w_rq_data)
    );

    v110ad_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rq_push),
        .i_data  (w_rq_data),
        .i_pop   (pop & ~empty),
        .o_full  (w_rq_full),
        .o_empty (empty),
        .o_head  (w_rq_head)
    );

    assign o_char_byte  = w_rq_head.char_byte;
    assign o_char_valid = w_rq_head.char_valid;
    assign o_stop_error = w_rq_head.stop_error;
    assign o_remote_cts = w_rq_head.remote_cts;
    assign o_synced     = w_rq_head.synced;
    assign o_last       = w_rq_head.last;

    a_fq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fq_push |-> !w_fq_full)
        else $error("frame queue written while full");

    a_rq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rq_push |-> !w_rq_full)
        else $error("result queue written while full");

    a_fq_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fq_pop |-> !w_fq_empty)
        else $error("frame taken from empty queue");

endmodule
